FILE: sv/arabic_contextual_shaper_top_macros.svh
// Assertion shorthands shared by the shaper RTL.
`ifndef ARABIC_CONTEXTUAL_SHAPER_TOP_MACROS_SVH
`define ARABIC_CONTEXTUAL_SHAPER_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ACS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ACS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/acs_pkg.sv
`timescale 1ns / 1ps

package acs_pkg;

    localparam int MARK_DEPTH_DEFAULT = 8;

    localparam int CP_W    = 21;
    localparam int GLYPH_W = 16;
    localparam int IDX_W   = 6;

    localparam logic [CP_W-1:0] TBL_BASE = 21'h000621;
    localparam int              TBL_SIZE = 42;

    localparam logic [CP_W-1:0] LAM_CP           = 21'h000644;
    localparam logic [IDX_W-1:0] LAM_IDX         = IDX_W'(LAM_CP - TBL_BASE);
    localparam logic [CP_W-1:0] ALEF_MADDA       = 21'h000622;
    localparam logic [CP_W-1:0] ALEF_HAMZA_ABOVE = 21'h000623;
    localparam logic [CP_W-1:0] ALEF_HAMZA_BELOW = 21'h000625;
    localparam logic [CP_W-1:0] ALEF_PLAIN       = 21'h000627;

    localparam logic [GLYPH_W-1:0] LIG_MADDA_ISO = 16'hFEF5;
    localparam logic [GLYPH_W-1:0] LIG_ABOVE_ISO = 16'hFEF7;
    localparam logic [GLYPH_W-1:0] LIG_BELOW_ISO = 16'hFEF9;
    localparam logic [GLYPH_W-1:0] LIG_ALEF_ISO  = 16'hFEFB;
    localparam logic [GLYPH_W-1:0] LIG_ALEF_FIN  = 16'hFEFC;

    localparam logic [CP_W-1:0] MARK_A_LO = 21'h00064B;
    localparam logic [CP_W-1:0] MARK_A_HI = 21'h00065F;
    localparam logic [CP_W-1:0] MARK_SUPERSCRIPT_ALEF = 21'h000670;
    localparam logic [CP_W-1:0] MARK_B_LO = 21'h0006D6;
    localparam logic [CP_W-1:0] MARK_B_HI = 21'h0006ED;

    localparam logic [GLYPH_W-1:0] HAMZA_ISO = 16'hFE80;

    typedef enum logic [1:0] {
        JC_NONE  = 2'd0,
        JC_RIGHT = 2'd1,
        JC_DUAL  = 2'd2
    } t_jc;

    typedef struct packed {
        t_jc                cls;
        logic [GLYPH_W-1:0] iso;
        logic [GLYPH_W-1:0] fin;
        logic [GLYPH_W-1:0] ini;
        logic [GLYPH_W-1:0] med;
    } t_forms;

    function automatic t_forms f_right(input logic [GLYPH_W-1:0] iso);
        t_forms r;
        r = '{JC_RIGHT, iso, iso + 16'd1, 16'd0, 16'd0};
        return r;
    endfunction

    function automatic t_forms f_dual(input logic [GLYPH_W-1:0] iso);
        t_forms r;
        r = '{JC_DUAL, iso, iso + 16'd1, iso + 16'd2, iso + 16'd3};
        return r;
    endfunction

    // Forms ROM, indexed by codepoint minus the table base. iso == 0: no letter.
    function automatic t_forms f_forms(input logic [IDX_W-1:0] idx);
        t_forms r;
        unique case (idx)
            6'd0:    r = '{JC_NONE, HAMZA_ISO, 16'd0, 16'd0, 16'd0};
            6'd1:    r = f_right(16'hFE81);
            6'd2:    r = f_right(16'hFE83);
            6'd3:    r = f_right(16'hFE85);
            6'd4:    r = f_right(16'hFE87);
            6'd5:    r = f_dual(16'hFE89);
            6'd6:    r = f_right(16'hFE8D);
            6'd7:    r = f_dual(16'hFE8F);
            6'd8:    r = f_right(16'hFE93);
            6'd9:    r = f_dual(16'hFE95);
            6'd10:   r = f_dual(16'hFE99);
            6'd11:   r = f_dual(16'hFE9D);
            6'd12:   r = f_dual(16'hFEA1);
            6'd13:   r = f_dual(16'hFEA5);
            6'd14:   r = f_right(16'hFEA9);
            6'd15:   r = f_right(16'hFEAB);
            6'd16:   r = f_right(16'hFEAD);
            6'd17:   r = f_right(16'hFEAF);
            6'd18:   r = f_dual(16'hFEB1);
            6'd19:   r = f_dual(16'hFEB5);
            6'd20:   r = f_dual(16'hFEB9);
            6'd21:   r = f_dual(16'hFEBD);
            6'd22:   r = f_dual(16'hFEC1);
            6'd23:   r = f_dual(16'hFEC5);
            6'd24:   r = f_dual(16'hFEC9);
            6'd25:   r = f_dual(16'hFECD);
            6'd32:   r = f_dual(16'hFED1);
            6'd33:   r = f_dual(16'hFED5);
            6'd34:   r = f_dual(16'hFED9);
            6'd35:   r = f_dual(16'hFEDD);
            6'd36:   r = f_dual(16'hFEE1);
            6'd37:   r = f_dual(16'hFEE5);
            6'd38:   r = f_dual(16'hFEE9);
            6'd39:   r = f_right(16'hFEED);
            6'd40:   r = f_right(16'hFEEF);
            6'd41:   r = f_dual(16'hFEF1);
            default: r = '{JC_NONE, 16'd0, 16'd0, 16'd0, 16'd0};
        endcase
        return r;
    endfunction

    function automatic logic f_is_mark(input logic [CP_W-1:0] cp);
        return (cp >= MARK_A_LO && cp <= MARK_A_HI) || cp == MARK_SUPERSCRIPT_ALEF ||
               (cp >= MARK_B_LO && cp <= MARK_B_HI);
    endfunction

    // Lam-alef ligature for an alef variant; 0 when cp is no alef variant.
    function automatic logic [GLYPH_W-1:0] f_lig(input logic [CP_W-1:0] cp,
                                                 input logic back);
        logic [GLYPH_W-1:0] base;
        unique case (cp)
            ALEF_MADDA:       base = LIG_MADDA_ISO;
            ALEF_HAMZA_ABOVE: base = LIG_ABOVE_ISO;
            ALEF_HAMZA_BELOW: base = LIG_BELOW_ISO;
            ALEF_PLAIN:       base = LIG_ALEF_ISO;
            default:          base = 16'd0;
        endcase
        if (base == 16'd0) begin
            return 16'd0;
        end
        if (base == LIG_ALEF_ISO && back) begin
            return LIG_ALEF_FIN;
        end
        return base + {15'd0, back};
    endfunction

    function automatic logic [GLYPH_W-1:0] f_shape(input t_forms f, input logic back,
                                                   input logic next);
        logic [GLYPH_W-1:0] g;
        priority if (back && next && f.med != 16'd0) begin
            g = f.med;
        end else if (back && f.fin != 16'd0) begin
            g = f.fin;
        end else if (next && f.ini != 16'd0) begin
            g = f.ini;
        end else begin
            g = f.iso;
        end
        return g;
    endfunction

endpackage

FILE: sv/acs_ram.sv
`timescale 1ns / 1ps

module acs_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/arabic_contextual_shaper_top.sv
`timescale 1ns / 1ps
// Arabic contextual shaper: takes one codepoint word per handshake and returns
// Presentation Forms-B glyph words in logical order. A table letter is held
// until the next non-mark word or the line end, then leaves in its isolated,
// final, initial or medial form; combining marks that follow it are kept in a
// small mark RAM and leave right after its glyph, one per cycle while the
// receiver is ready. Lam followed by an alef variant leaves as one ligature and
// the marks between them are dropped silently; marks beyond the RAM depth are
// dropped and flagged on the letter's glyph. With the receiver ready, an item
// is taken in the accept cycle and then worked in S_MAIN, which gives at most
// one glyph word. Flushing a held letter reads each stored mark back through
// the RAM's registered port in S_DRAIN, then places the new character in S_NEW
// when marks were drained or the new character is no letter; a letter still
// held at the line end is flushed in S_LINE. A receiver that holds off a
// pending word stalls the work. Upstream is stalled while an item is in work.
// The mark RAM holds no reset contents and needs no clearing pass after reset.

`include "arabic_contextual_shaper_top_macros.svh"

module arabic_contextual_shaper_top #(
    parameter int MARK_DEPTH = acs_pkg::MARK_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [20:0] codepoint, [23:21] zero
    input  logic        i_s_tlast,   // line_end
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [20:0] glyph, [23:21] zero
    output logic        o_m_tlast,   // line_last
    output logic [1:0]  o_m_tuser    // [0] run_last, [1] mark_dropped
);

    localparam int AW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int CW = $clog2(MARK_DEPTH + 1);
    localparam int CP_W    = acs_pkg::CP_W;
    localparam int GLYPH_W = acs_pkg::GLYPH_W;
    localparam int IDX_W   = acs_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAIN,
        S_DRAIN,
        S_NEW,
        S_LINE
    } t_state;

    // ---------------------------------------------------------------------
    // Control state
    t_state           r_state,      n_state;
    logic             r_held_valid, n_held_valid;
    logic [IDX_W-1:0] r_held_idx,   n_held_idx;
    logic             r_held_back,  n_held_back;
    acs_pkg::t_jc     r_prev,       n_prev;
    logic [CW-1:0]    r_mark_cnt,   n_mark_cnt;
    logic             r_mark_lost,  n_mark_lost;
    logic [CW-1:0]    r_idx,        n_idx;
    logic             r_after_new,  n_after_new;
    logic             r_m_valid,    n_m_valid;

    // Captured item (payload, no reset)
    logic [CP_W-1:0]  r_cp;
    logic             r_line_end;
    logic             r_is_mark;
    logic             r_is_tbl;
    logic [IDX_W-1:0] r_tbl_idx;
    acs_pkg::t_jc     r_cls;

    // Output word register
    logic [CP_W-1:0]  r_out_glyph;
    logic             r_out_run_last;
    logic             r_out_line_last;
    logic             r_out_drop;

    // ---------------------------------------------------------------------
    // Input decode at the accept edge
    logic             acc;
    logic [CP_W-1:0]  in_cp;
    logic [CP_W-1:0]  in_off;
    logic             in_rng;
    acs_pkg::t_forms  in_f;
    logic             in_tbl;
    logic             in_mark;

    assign o_s_tready = (r_state == S_IDLE);
    assign acc        = i_s_tvalid && o_s_tready;
    assign in_cp      = i_s_tdata[CP_W-1:0];
    assign in_off     = in_cp - acs_pkg::TBL_BASE;
    assign in_rng     = (in_cp >= acs_pkg::TBL_BASE) &&
                        (in_off < CP_W'(acs_pkg::TBL_SIZE));
    assign in_f       = acs_pkg::f_forms(in_off[IDX_W-1:0]);
    assign in_tbl     = in_rng && (in_f.iso != '0);
    assign in_mark    = acs_pkg::f_is_mark(in_cp);

    // ---------------------------------------------------------------------
    // Mark RAM: written on the accept edge, read back during the drain.
    logic                ram_wr_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [GLYPH_W-1:0]  ram_rd_data;
    logic [CW-1:0]       idx_nx;
    logic                out_rdy;
    logic                emit;

    assign ram_wr_en = acc && in_mark && r_held_valid && (r_mark_cnt < CW'(MARK_DEPTH));
    assign idx_nx    = r_idx + CW'(1);

    // Keep the RAM read address one entry ahead: the output shows entry r_idx while
    // draining, and entry 0 is addressed in the cycle before the drain starts.
    always_comb begin
        ram_rd_addr = '0;
        if (r_state == S_DRAIN) begin
            ram_rd_addr = (emit) ? idx_nx[AW-1:0] : r_idx[AW-1:0];
        end
    end

    acs_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (MARK_DEPTH)
    ) u_mark_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_mark_cnt[AW-1:0]),
        .i_wr_data (in_cp[GLYPH_W-1:0]),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------------
    // Shaping of the held letter
    acs_pkg::t_forms    held_f;
    logic [GLYPH_W-1:0] lig;
    logic               is_lig;
    logic               join_next;

    assign held_f    = acs_pkg::f_forms(r_held_idx);
    assign lig       = acs_pkg::f_lig(r_cp, r_held_back);
    assign is_lig    = r_held_valid && (r_held_idx == acs_pkg::LAM_IDX) && (lig != '0);
    assign join_next = (held_f.cls == acs_pkg::JC_DUAL) && (r_cls != acs_pkg::JC_NONE);

    // The output register can take a new word when empty or being drained.
    assign out_rdy = !r_m_valid || i_m_tready;

    // ---------------------------------------------------------------------
    // Sequencer
    logic            do_new;
    logic [CP_W-1:0] e_glyph;
    logic            e_last;
    logic            e_drop;

    always_comb begin
        n_state      = r_state;
        n_held_valid = r_held_valid;
        n_held_idx   = r_held_idx;
        n_held_back  = r_held_back;
        n_prev       = r_prev;
        n_mark_cnt   = r_mark_cnt;
        n_mark_lost  = r_mark_lost;
        n_idx        = r_idx;
        n_after_new  = r_after_new;
        do_new       = 1'b0;
        emit         = 1'b0;
        e_glyph      = r_cp;
        e_last       = 1'b1;
        e_drop       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = S_MAIN;
                    // store a mark behind the held letter, or flag the overflow
                    if (in_mark && r_held_valid) begin
                        if (r_mark_cnt < CW'(MARK_DEPTH)) begin
                            n_mark_cnt = r_mark_cnt + CW'(1);
                        end else begin
                            n_mark_lost = 1'b1;
                        end
                    end
                end
            end
            S_MAIN: begin
                priority if (r_is_mark) begin
                    if (r_held_valid) begin
                        n_state = (r_line_end) ? S_LINE : S_IDLE;
                    end else if (out_rdy) begin
                        // mark with nothing to sit on: pass it through
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (is_lig) begin
                    if (out_rdy) begin
                        emit         = 1'b1;
                        e_glyph      = CP_W'(lig);
                        e_drop       = r_mark_lost;
                        n_held_valid = 1'b0;
                        n_mark_cnt   = '0;
                        n_mark_lost  = 1'b0;
                        n_prev       = acs_pkg::JC_RIGHT;
                        n_state      = S_IDLE;
                    end
                end else if (r_held_valid) begin
                    if (out_rdy) begin
                        emit        = 1'b1;
                        e_glyph     = CP_W'(acs_pkg::f_shape(held_f, r_held_back, join_next));
                        e_drop      = r_mark_lost;
                        e_last      = (r_mark_cnt == '0) && r_is_tbl && !r_line_end;
                        n_mark_lost = 1'b0;
                        if (r_mark_cnt != '0) begin
                            n_idx       = '0;
                            n_after_new = 1'b1;
                            n_state     = S_DRAIN;
                        end else begin
                            n_held_valid = 1'b0;
                            do_new       = 1'b1;
                        end
                    end
                end else begin
                    do_new = 1'b1;
                end
            end
            S_DRAIN: begin
                if (out_rdy) begin
                    emit    = 1'b1;
                    e_glyph = CP_W'(ram_rd_data);
                    e_last  = (idx_nx == r_mark_cnt) &&
                              !(r_after_new && (!r_is_tbl || r_line_end));
                    n_idx   = idx_nx;
                    if (idx_nx == r_mark_cnt) begin
                        n_held_valid = 1'b0;
                        n_mark_cnt   = '0;
                        n_state      = (r_after_new) ? S_NEW : S_IDLE;
                    end
                end
            end
            S_NEW: begin
                do_new = 1'b1;
            end
            S_LINE: begin
                // line end: flush the held letter with nothing joining after it
                if (out_rdy) begin
                    emit        = 1'b1;
                    e_glyph     = CP_W'(acs_pkg::f_shape(held_f, r_held_back, 1'b0));
                    e_drop      = r_mark_lost;
                    e_last      = (r_mark_cnt == '0);
                    n_mark_lost = 1'b0;
                    if (r_mark_cnt != '0) begin
                        n_idx       = '0;
                        n_after_new = 1'b0;
                        n_state     = S_DRAIN;
                    end else begin
                        n_held_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Place the non-mark character once the old letter is gone.
        if (do_new) begin
            priority if (r_is_tbl) begin
                n_held_valid = 1'b1;
                n_held_idx   = r_tbl_idx;
                n_held_back  = (r_prev == acs_pkg::JC_DUAL);
                n_mark_cnt   = '0;
                n_mark_lost  = 1'b0;
                n_prev       = r_cls;
                n_state      = (r_line_end) ? S_LINE : S_IDLE;
            end else if (!emit && out_rdy) begin
                emit    = 1'b1;
                e_glyph = r_cp;
                e_last  = 1'b1;
                n_prev  = acs_pkg::JC_NONE;
                n_state = S_IDLE;
            end else begin
                n_state = S_NEW;
            end
        end

        // A line end leaves nothing to join for the next line.
        if (r_state != S_IDLE && n_state == S_IDLE && r_line_end) begin
            n_prev = acs_pkg::JC_NONE;
        end

        n_m_valid = (emit) ? 1'b1 : (r_m_valid && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cp       <= in_cp;
            r_line_end <= i_s_tlast;
            r_is_mark  <= in_mark;
            r_is_tbl   <= in_tbl;
            r_tbl_idx  <= in_off[IDX_W-1:0];
            r_cls      <= (in_tbl) ? in_f.cls : acs_pkg::JC_NONE;
        end
        if (emit) begin
            r_out_glyph     <= e_glyph;
            r_out_run_last  <= e_last;
            r_out_line_last <= e_last && r_line_end;
            r_out_drop      <= e_drop;
        end
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held_valid <= 1'b0;
            r_held_idx   <= '0;
            r_held_back  <= 1'b0;
            r_prev       <= acs_pkg::JC_NONE;
            r_mark_cnt   <= '0;
            r_mark_lost  <= 1'b0;
            r_idx        <= '0;
            r_after_new  <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held_valid <= n_held_valid;
            r_held_idx   <= n_held_idx;
            r_held_back  <= n_held_back;
            r_prev       <= n_prev;
            r_mark_cnt   <= n_mark_cnt;
            r_mark_lost  <= n_mark_lost;
            r_idx        <= n_idx;
            r_after_new  <= n_after_new;
            r_m_valid    <= n_m_valid;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {3'b000, r_out_glyph};
    assign o_m_tlast  = r_out_line_last;
    assign o_m_tuser  = {r_out_drop, r_out_run_last};

    // ---------------------------------------------------------------------
    // Assertions
    `ACS_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_mark_cnt <= CW'(MARK_DEPTH), "mark count beyond store depth")
    `ACS_ASSERT_IMP(a_drain_idx, i_clk, i_rst_n, r_state == S_DRAIN, r_held_valid && (r_idx < r_mark_cnt), "drain index outside stored marks")
    `ACS_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, emit, out_rdy, "glyph word overwrites a pending word")
    `ACS_ASSERT_IMP(a_line_last, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, o_m_tuser[0], "line end word not last of its item")
    `ACS_ASSERT_NXT(a_busy_after_acc, i_clk, i_rst_n, acc, !o_s_tready, "new word taken while an item is in work")

endmodule
